@@ design/per_flow_batch_admission_assert.svh @@
// Assertion macros for the per-flow batch admission block.
// Included by the top level; expands to nothing when SYNTH is defined.
`ifndef PER_FLOW_BATCH_ADMISSION_ASSERT_SVH
`define PER_FLOW_BATCH_ADMISSION_ASSERT_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset
`define PFBA_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define PFBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define PFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFBA_ASSERT_NOW(lbl, clk, rst_n, prop, msg)
`define PFBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/pfba_pkg.sv @@
// Shared types and codes for the per-flow batch admission block.
// No dependencies; imported by every module of the block.
package pfba_pkg;

    localparam int KEY_W      = 64;
    localparam int LEN_W      = 16;
    localparam int MSGS_W     = 8;
    localparam int BYTES_W    = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // function codes of an input word
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // verdict codes
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
    localparam logic [1:0] VERDICT_FULL     = 2'd1;
    localparam logic [1:0] VERDICT_DEFERRED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSGS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 2'd2;

    // configuration reset values
    localparam logic [MSGS_W-1:0]  RST_MAX_MSGS  = 8'd8;
    localparam logic [BYTES_W-1:0] RST_MAX_BYTES = 20'd16384;
    localparam logic [BYTES_W-1:0] RST_MAX_TOTAL = 20'd65536;

    typedef struct packed {
        logic [MSGS_W-1:0]  max_msgs;
        logic [BYTES_W-1:0] max_bytes;
        logic [BYTES_W-1:0] max_total;
    } t_cfg;

    // per-slot counters held in the counter memory
    typedef struct packed {
        logic [MSGS_W-1:0]  msgs;
        logic [BYTES_W-1:0] bytes;
        logic               capped;
    } t_cnt;

    // write request from the sequencer to the table
    typedef struct packed {
        logic             we_key;
        logic             we_cnt;
        logic [KEY_W-1:0] key;
        t_cnt             cnt;
    } t_tbl_wr;

    typedef struct packed {
        logic [1:0]         verdict;
        logic [2:0]         slot_index;
        logic               new_flow;
        logic [MSGS_W-1:0]  slot_msgs;
        logic [BYTES_W-1:0] slot_bytes;
        logic               slot_capped;
        logic [BYTES_W-1:0] total_bytes_out;
        logic [3:0]         flows_in_use;
    } t_result;

endpackage

@@ design/pfba_if.sv @@
// Channel interfaces of the per-flow batch admission block.
// Depends on pfba_pkg for field widths.
interface pfba_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [pfba_pkg::KEY_W-1:0] flow_key;
    logic [pfba_pkg::LEN_W-1:0] msg_bytes;

    modport source (output valid, func, flow_key, msg_bytes, input ready);
    modport sink   (input valid, func, flow_key, msg_bytes, output ready);
endinterface

interface pfba_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   verdict;
    logic [2:0]                   slot_index;
    logic                         new_flow;
    logic [pfba_pkg::MSGS_W-1:0]  slot_msgs;
    logic [pfba_pkg::BYTES_W-1:0] slot_bytes;
    logic                         slot_capped;
    logic [pfba_pkg::BYTES_W-1:0] total_bytes_out;
    logic [3:0]                   flows_in_use;

    modport source (output valid, verdict, slot_index, new_flow, slot_msgs, slot_bytes,
                    slot_capped, total_bytes_out, flows_in_use, input ready);
    modport sink   (input valid, verdict, slot_index, new_flow, slot_msgs, slot_bytes,
                    slot_capped, total_bytes_out, flows_in_use, output ready);
endinterface

interface pfba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pfba_pkg::CFG_IDX_W-1:0]  index;
    logic [pfba_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/per_flow_batch_admission.sv @@
// Per-flow batch admission control, top level.
// Channels: i_in takes one word per message (func, flow_key, msg_bytes);
// func add offers a message, func clear empties the flow table. o_out gives
// one result word per input word: verdict, slot, slot counters, shared byte
// total and flows in use. i_cfg writes the three cap registers by index;
// it is always ready, and unknown indexes are dropped.
// Timing: an add word, once accepted, scans the slots in use in allocation
// order through the key memory read port, which compares one slot per
// cycle; the scan stops at a key match or after the last slot in use, and
// is skipped for an empty table. A decision state then admits or defers
// the word and writes back a slot that it allocates or updates, and the
// result is moved into the output register. A clear word goes straight to
// its result. A new input word is accepted only once the last result has left the sequencer.
// Reset: synchronous; empties the table, loads the cap defaults and clears
// the output register. The memories need no clearing pass.
// Stall: the output register holds a finished word while o_out.ready is
// low; the next input word is accepted meanwhile and its result waits in
// the sequencer until the output register frees.
// Depends on pfba_pkg, pfba_if, pfba_cfg, pfba_table and pfba_seq.
`include "per_flow_batch_admission_assert.svh"
module per_flow_batch_admission #(
    parameter int MAX_FLOWS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfba_in_if.sink     i_in,
    pfba_cfg_if.sink    i_cfg,
    pfba_out_if.source  o_out
);
    import pfba_pkg::*;

    localparam int SLOT_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CNT_W  = $clog2(MAX_FLOWS + 1);

    t_cfg              cfg;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    t_tbl_wr           tbl_wr;
    logic [KEY_W-1:0]  rd_key;
    t_cnt              rd_cnt;
    logic              res_valid;
    t_result           res;
    logic              res_take;
    logic              r_out_valid;
    t_result           r_out;

    pfba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    pfba_table #(
        .DEPTH  (MAX_FLOWS),
        .ADDR_W (SLOT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr      (tbl_wr),
        .o_rd_key  (rd_key),
        .o_rd_cnt  (rd_cnt)
    );

    pfba_seq #(
        .MAX_FLOWS (MAX_FLOWS),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_func      (i_in.func),
        .i_flow_key  (i_in.flow_key),
        .i_msg_bytes (i_in.msg_bytes),
        .i_cfg       (cfg),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr        (tbl_wr),
        .i_rd_key    (rd_key),
        .i_rd_cnt    (rd_cnt),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_take) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.verdict         = r_out.verdict;
    assign o_out.slot_index      = r_out.slot_index;
    assign o_out.new_flow        = r_out.new_flow;
    assign o_out.slot_msgs       = r_out.slot_msgs;
    assign o_out.slot_bytes      = r_out.slot_bytes;
    assign o_out.slot_capped     = r_out.slot_capped;
    assign o_out.total_bytes_out = r_out.total_bytes_out;
    assign o_out.flows_in_use    = r_out.flows_in_use;

    // a word is worked on alone: no second acceptance right after one
    `PFBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input accepted twice in a row")
    // a deferred word never allocates a slot
    `PFBA_ASSERT_IMPL(a_deferred_not_new, i_clk, i_rst_n, o_out.valid && (o_out.verdict == VERDICT_DEFERRED), !o_out.new_flow, "deferred word reports a new flow")
    // a fresh slot holds exactly its first message and is not capped
    `PFBA_ASSERT_IMPL(a_new_first_msg, i_clk, i_rst_n, o_out.valid && o_out.new_flow, (o_out.slot_msgs == 8'd1) && !o_out.slot_capped, "new flow slot counters wrong")
    // verdict is one of the defined codes
    `PFBA_ASSERT_IMPL(a_verdict_code, i_clk, i_rst_n, o_out.valid, (o_out.verdict == VERDICT_ACCEPTED) || (o_out.verdict == VERDICT_FULL) || (o_out.verdict == VERDICT_DEFERRED), "undefined verdict code")

endmodule

@@ design/pfba_cfg.sv @@
// Configuration registers of the per-flow batch admission block.
// Depends on pfba_pkg for register indexes and reset values.
module pfba_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [pfba_pkg::CFG_DATA_W-1:0] i_data,
    output pfba_pkg::t_cfg                  o_cfg
);
    import pfba_pkg::*;

    t_cfg r_cfg;

    // take every write at once
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // write the addressed register, drop indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_msgs  <= RST_MAX_MSGS;
            r_cfg.max_bytes <= RST_MAX_BYTES;
            r_cfg.max_total <= RST_MAX_TOTAL;
        end else if (i_valid) begin
            case (i_index)
                CFG_MAX_MSGS:  r_cfg.max_msgs  <= i_data[MSGS_W-1:0];
                CFG_MAX_BYTES: r_cfg.max_bytes <= i_data[BYTES_W-1:0];
                CFG_MAX_TOTAL: r_cfg.max_total <= i_data[BYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/pfba_table.sv @@
// Flow table: key memory and counter memory, one read and one write port each.
// Depends on pfba_pkg for the entry and write request types.
module pfba_table #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                        i_clk,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  pfba_pkg::t_tbl_wr           i_wr,
    output logic [pfba_pkg::KEY_W-1:0]  o_rd_key,
    output pfba_pkg::t_cnt              o_rd_cnt
);
    import pfba_pkg::*;

    logic [KEY_W-1:0] key_mem [DEPTH];
    t_cnt             cnt_mem [DEPTH];
    logic [KEY_W-1:0] r_rd_key;
    t_cnt             r_rd_cnt;

    // write ports
    always_ff @(posedge i_clk) begin
        if (i_wr.we_key) begin
            key_mem[i_wr_addr] <= i_wr.key;
        end
        if (i_wr.we_cnt) begin
            cnt_mem[i_wr_addr] <= i_wr.cnt;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_key <= key_mem[i_rd_addr];
        r_rd_cnt <= cnt_mem[i_rd_addr];
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_cnt = r_rd_cnt;

endmodule

@@ design/pfba_seq.sv @@
// Sequencer: scans the flow table, decides admission and writes the slot back.
// Depends on pfba_pkg; drives pfba_table through its read and write ports.
module pfba_seq #(
    parameter int MAX_FLOWS = 8,
    parameter int SLOT_W    = 3,
    parameter int CNT_W     = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [pfba_pkg::KEY_W-1:0]  i_flow_key,
    input  logic [pfba_pkg::LEN_W-1:0]  i_msg_bytes,
    input  pfba_pkg::t_cfg              i_cfg,
    output logic [SLOT_W-1:0]           o_rd_addr,
    output logic [SLOT_W-1:0]           o_wr_addr,
    output pfba_pkg::t_tbl_wr           o_wr,
    input  logic [pfba_pkg::KEY_W-1:0]  i_rd_key,
    input  pfba_pkg::t_cnt              i_rd_cnt,
    output logic                        o_res_valid,
    output pfba_pkg::t_result           o_res,
    input  logic                        i_res_take
);
    import pfba_pkg::*;

    localparam int CMP_W = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEW,
        S_UPD,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [SLOT_W-1:0]  r_idx;
    logic [CNT_W-1:0]   r_used;
    logic [BYTES_W-1:0] r_total;
    logic [KEY_W-1:0]   r_key;
    logic [LEN_W-1:0]   r_bytes;
    t_cnt               r_cnt;
    t_result            r_res;

    logic [BYTES_W:0]   tot_sum;
    logic               tot_over;
    logic [BYTES_W:0]   byte_sum;
    logic [CMP_W-1:0]   idx_inc;
    logic               scan_last;
    logic               key_hit;
    logic               used_full;
    logic [CNT_W-1:0]   used_inc;
    logic               new_defer;
    logic               new_full;
    logic               upd_defer;
    logic [MSGS_W-1:0]  upd_msgs;
    logic               upd_full;
    logic [SLOT_W-1:0]  new_slot;
    logic [SLOT_W+2:0]  new_ext;
    logic [SLOT_W+2:0]  cur_ext;
    logic [CNT_W+3:0]   used_ext;
    logic [CNT_W+3:0]   used_inc_ext;
    t_cnt               cnt_next;

    // shared byte total check
    assign tot_sum  = {1'b0, r_total} + (BYTES_W+1)'(r_bytes);
    assign tot_over = tot_sum > {1'b0, i_cfg.max_total};

    // scan progress over the slots in use
    assign idx_inc   = CMP_W'(r_idx) + CMP_W'(1);
    assign scan_last = idx_inc == CMP_W'(r_used);
    assign key_hit   = i_rd_key == r_key;

    // new flow admission
    assign used_full = CMP_W'(r_used) >= CMP_W'(MAX_FLOWS);
    assign used_inc  = r_used + CNT_W'(1);
    assign new_defer = used_full || tot_over;
    assign new_full  = (MSGS_W'(1) >= i_cfg.max_msgs) ||
                       (BYTES_W'(r_bytes) >= i_cfg.max_bytes);
    assign new_slot  = r_used[SLOT_W-1:0];

    // known flow admission
    assign byte_sum  = {1'b0, r_cnt.bytes} + (BYTES_W+1)'(r_bytes);
    assign upd_defer = (r_cnt.msgs >= i_cfg.max_msgs) ||
                       (byte_sum > {1'b0, i_cfg.max_bytes}) || tot_over;
    assign upd_msgs  = r_cnt.msgs + MSGS_W'(1);
    assign upd_full  = (upd_msgs >= i_cfg.max_msgs) ||
                       (byte_sum[BYTES_W-1:0] >= i_cfg.max_bytes);

    // report fields keep the low bits of slot and flow counts
    assign new_ext      = (SLOT_W+3)'(new_slot);
    assign cur_ext      = (SLOT_W+3)'(r_idx);
    assign used_ext     = (CNT_W+4)'(r_used);
    assign used_inc_ext = (CNT_W+4)'(used_inc);

    // counters written back to the slot
    always_comb begin
        if (r_state == S_NEW) begin
            cnt_next = '{msgs: MSGS_W'(1), bytes: BYTES_W'(r_bytes), capped: 1'b0};
        end else if (upd_defer) begin
            cnt_next = '{msgs: r_cnt.msgs, bytes: r_cnt.bytes, capped: 1'b1};
        end else begin
            cnt_next = '{msgs: upd_msgs, bytes: byte_sum[BYTES_W-1:0],
                         capped: r_cnt.capped};
        end
    end

    // read address: first slot outside the scan, next slot while the scan advances
    always_comb begin
        case (r_state)
            S_SCAN: begin
                if (!key_hit && !scan_last) begin
                    o_rd_addr = r_idx + SLOT_W'(1);
                end else begin
                    o_rd_addr = r_idx;
                end
            end
            default: o_rd_addr = '0;
        endcase
    end

    // write back on allocation or update
    always_comb begin
        o_wr_addr     = (r_state == S_NEW) ? new_slot : r_idx;
        o_wr.we_key   = (r_state == S_NEW) && !new_defer;
        o_wr.we_cnt   = ((r_state == S_NEW) && !new_defer) || (r_state == S_UPD);
        o_wr.key      = r_key;
        o_wr.cnt      = cnt_next;
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_res_valid = r_state == S_OUT;
    assign o_res       = r_res;

    // sequence one word through scan, decision and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key   <= i_flow_key;
                        r_bytes <= i_msg_bytes;
                        r_idx   <= '0;
                        if (i_func == FUNC_CLEAR) begin
                            r_used  <= '0;
                            r_total <= '0;
                            r_res   <= '{verdict: VERDICT_ACCEPTED, slot_index: 3'd0,
                                         new_flow: 1'b0, slot_msgs: '0, slot_bytes: '0,
                                         slot_capped: 1'b0, total_bytes_out: '0,
                                         flows_in_use: 4'd0};
                            r_state <= S_OUT;
                        end else if (r_used == '0) begin
                            r_state <= S_NEW;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (key_hit) begin
                        r_cnt   <= i_rd_cnt;
                        r_state <= S_UPD;
                    end else if (scan_last) begin
                        r_state <= S_NEW;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                S_NEW: begin
                    if (new_defer) begin
                        r_res <= '{verdict: VERDICT_DEFERRED, slot_index: 3'd0,
                                   new_flow: 1'b0, slot_msgs: '0, slot_bytes: '0,
                                   slot_capped: 1'b0, total_bytes_out: r_total,
                                   flows_in_use: used_ext[3:0]};
                    end else begin
                        r_used  <= used_inc;
                        r_total <= tot_sum[BYTES_W-1:0];
                        r_res   <= '{verdict: new_full ? VERDICT_FULL : VERDICT_ACCEPTED,
                                     slot_index: new_ext[2:0], new_flow: 1'b1,
                                     slot_msgs: cnt_next.msgs, slot_bytes: cnt_next.bytes,
                                     slot_capped: 1'b0,
                                     total_bytes_out: tot_sum[BYTES_W-1:0],
                                     flows_in_use: used_inc_ext[3:0]};
                    end
                    r_state <= S_OUT;
                end
                S_UPD: begin
                    if (upd_defer) begin
                        r_res <= '{verdict: VERDICT_DEFERRED, slot_index: cur_ext[2:0],
                                   new_flow: 1'b0, slot_msgs: cnt_next.msgs,
                                   slot_bytes: cnt_next.bytes, slot_capped: 1'b1,
                                   total_bytes_out: r_total,
                                   flows_in_use: used_ext[3:0]};
                    end else begin
                        r_total <= tot_sum[BYTES_W-1:0];
                        r_res   <= '{verdict: upd_full ? VERDICT_FULL : VERDICT_ACCEPTED,
                                     slot_index: cur_ext[2:0], new_flow: 1'b0,
                                     slot_msgs: cnt_next.msgs, slot_bytes: cnt_next.bytes,
                                     slot_capped: cnt_next.capped,
                                     total_bytes_out: tot_sum[BYTES_W-1:0],
                                     flows_in_use: used_ext[3:0]};
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
